FILE: src/stereo_sine_slew_distortion_assert.svh
// assertion macros for the slew distortion rtl
// expects clk and arst_n in the scope of each use
`ifndef STEREO_SINE_SLEW_DISTORTION_ASSERT_SVH
`define STEREO_SINE_SLEW_DISTORTION_ASSERT_SVH

// same-cycle implication
`define SSD_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/ssd_pkg.sv
// types and constants for the stereo slew distortion block
// no dependencies
package ssd_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int CFG_DATA_W = 22;

	localparam logic [22:0] PHASE_K = 23'd6710746;
	localparam logic [23:0] PHASE_MAX = 24'd16776865;
	localparam logic [16:0] UNITY_Q16 = 17'd65536;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	typedef enum logic [1:0] {
		REG_BOOST_GAIN,
		REG_RATE_SCALE,
		REG_OUTPUT_LEVEL,
		REG_WET_MIX
	} reg_idx_t;

	typedef struct packed {
		logic [21:0] boost_gain;
		logic [18:0] rate_scale;
		logic [16:0] output_level;
		logic [16:0] wet_mix;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_word_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_MUL_X,
		OP_GET_X,
		OP_GET_T,
		OP_MUL_T,
		OP_GET_Q,
		OP_MUL_Q,
		OP_RD_SIN,
		OP_MUL_LIM,
		OP_GET_LIM,
		OP_UPDATE,
		OP_MUL_LVL,
		OP_GET_Y,
		OP_MUL_DRY,
		OP_MUL_WET,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic load;
		op_t op;
		logic commit;
	} cmd_t;

endpackage

FILE: src/ssd_chan.sv
// one channel datapath: shared multiplier, sine rom, held value, result register
// depends on ssd_pkg
module ssd_chan #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input ssd_pkg::cmd_t cmd,
	input ssd_pkg::cfg_t cfg,
	input logic signed [ssd_pkg::SAMPLE_BITS-1:0] sample,
	output logic signed [ssd_pkg::SAMPLE_BITS-1:0] result
);
	import ssd_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int F = SB - 1;
	localparam int AW = (SB + 2 > 32) ? SB + 2 : 32;
	localparam int BW = 24;
	localparam int PW = AW + BW;
	localparam int XW = SB + 7;
	localparam int DW = ((XW > 32) ? XW : 32) + 1;
	localparam int LS = 40 - F;
	localparam int LW = SB + 3;
	localparam int CW = ((DW > LW + 1) ? DW : LW + 1) + 1;
	localparam int TW = SB + 1;
	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int YW = PW - 15;

	localparam logic signed [XW:0] ONE_X = {{(XW - F){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [PW-1:0] HALF16 = PW'(32768);
	localparam logic signed [PW-1:0] HALF24 = PW'(8388608);
	localparam logic signed [PW-1:0] LIM_HALF = PW'(1) <<< (LS - 1);

	typedef logic [24:0] sine_word_t;
	typedef sine_word_t sine_rom_t [SINE_TABLE_DEPTH+1];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint unsigned a;
		longint unsigned a2;
		longint unsigned term;
		longint sum;
		longint v;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			a = (longint'(i) * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
			a2 = (a * a) >> 30;
			term = a;
			sum = longint'(a);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * a2) >> 30) / TAYLOR_DIV[n-1];
				if ((n & 1) != 0)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			v = (sum + 32) >>> 6;
			if (v < 0)
				v = 0;
			if (v > 64'sd16777216)
				v = 64'sd16777216;
			rom[i] = 25'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic signed [SB-1:0] dry_q;
	logic signed [31:0] held_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic signed [XW-1:0] x_q;
	logic signed [DW-1:0] d_q;
	logic [TW-1:0] t_q;
	logic [24:0] q_q;
	logic [24:0] sine_q;
	logic [LW-1:0] lim_q;
	logic signed [31:0] y_q;
	logic signed [SB-1:0] res_q;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic [16:0] dry_wt;

	assign dry_wt = UNITY_Q16 - cfg.wet_mix;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_X: begin
				mul_a = AW'(dry_q);
				mul_b = BW'(cfg.boost_gain);
			end
			OP_MUL_T: begin
				mul_a = AW'(t_q);
				mul_b = BW'(PHASE_K);
			end
			OP_MUL_Q: begin
				mul_a = AW'(q_q);
				mul_b = BW'(SINE_TABLE_DEPTH);
			end
			OP_MUL_LIM: begin
				mul_a = AW'(sine_q);
				mul_b = BW'(cfg.rate_scale);
			end
			OP_MUL_LVL: begin
				mul_a = AW'(held_q);
				mul_b = BW'(cfg.output_level);
			end
			OP_MUL_DRY: begin
				mul_a = AW'(dry_q);
				mul_b = BW'(dry_wt);
			end
			OP_MUL_WET: begin
				mul_a = AW'(y_q);
				mul_b = BW'(cfg.wet_mix);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// drive and step
	logic signed [PW-1:0] x_rnd;
	logic signed [DW-1:0] d_w;
	logic rise;
	logic signed [XW:0] t_w;
	logic [TW-1:0] t_c;

	assign x_rnd = prod_q + HALF16;
	assign d_w = DW'(x_q) - DW'(held_q);
	assign rise = !d_w[DW-1] && (d_w != '0);

	always_comb begin
		if (rise)
			t_w = ONE_X - (XW + 1)'(x_q);
		else
			t_w = (XW + 1)'(x_q) + ONE_X;
		if (t_w[XW])
			t_c = '0;
		else if (|t_w[XW-1:TW])
			t_c = '1;
		else
			t_c = t_w[TW-1:0];
	end

	// phase fold and table index
	logic [24:0] h_full;
	logic [23:0] h_c;
	logic [24:0] h_ext;
	logic [24:0] q_w;
	logic signed [PW-1:0] i_rnd;
	logic [IW-1:0] idx;

	assign h_full = prod_q[F+24:F];
	assign h_c = (h_full > 25'(PHASE_MAX)) ? PHASE_MAX : h_full[23:0];
	assign h_ext = {1'b0, h_c};
	assign q_w = (h_c <= 24'h800000) ? (h_ext << 1) : ((25'h1000000 - h_ext) << 1);
	assign i_rnd = prod_q + HALF24;
	assign idx = i_rnd[24+IW-1:24];

	// slew limit and held update
	logic signed [PW-1:0] l_rnd;
	logic signed [CW-1:0] dc;
	logic signed [CW-1:0] lc;
	logic signed [CW-1:0] dl;
	logic signed [CW:0] hs;
	logic signed [31:0] held_d;

	assign l_rnd = prod_q + LIM_HALF;
	assign dc = CW'(d_q);
	assign lc = CW'(lim_q);

	always_comb begin
		if (!dc[CW-1] && (dc > lc))
			dl = lc;
		else if (dc[CW-1] && (dc < -lc))
			dl = -lc;
		else
			dl = dc;
		hs = (CW + 1)'(held_q) + (CW + 1)'(dl);
		if ((&hs[CW:31]) || !(|hs[CW:31]))
			held_d = hs[31:0];
		else if (hs[CW])
			held_d = {1'b1, {31{1'b0}}};
		else
			held_d = {1'b0, {31{1'b1}}};
	end

	// level, mix and output saturation
	logic signed [PW-1:0] y_rnd;
	logic signed [PW:0] mix_s;
	logic signed [YW-1:0] y_sel;
	logic signed [SB-1:0] res_d;

	assign y_rnd = prod_q + HALF16;

	always_comb begin
		mix_s = (PW + 1)'(acc_q) + (PW + 1)'(prod_q) + (PW + 1)'(HALF16);
		if (!cfg.wet_mix[16])
			y_sel = mix_s[PW:16];
		else
			y_sel = YW'(y_q);
		if ((&y_sel[YW-1:SB-1]) || !(|y_sel[YW-1:SB-1]))
			res_d = y_sel[SB-1:0];
		else if (y_sel[YW-1])
			res_d = {1'b1, {(SB - 1){1'b0}}};
		else
			res_d = {1'b0, {(SB - 1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			dry_q <= sample;
		case (cmd.op)
			OP_MUL_X, OP_MUL_T, OP_MUL_Q, OP_MUL_LIM, OP_MUL_LVL, OP_MUL_DRY: begin
				prod_q <= prod;
			end
			OP_MUL_WET: begin
				acc_q <= prod_q;
				prod_q <= prod;
			end
			OP_GET_X: begin
				x_q <= x_rnd[XW+15:16];
			end
			OP_GET_T: begin
				d_q <= d_w;
				t_q <= t_c;
			end
			OP_GET_Q: begin
				q_q <= q_w;
			end
			OP_RD_SIN: begin
				sine_q <= SINE_ROM[idx];
			end
			OP_GET_LIM: begin
				lim_q <= l_rnd[LS+LW-1:LS];
			end
			OP_GET_Y: begin
				if (!cfg.output_level[16])
					y_q <= y_rnd[47:16];
				else
					y_q <= held_q;
			end
			OP_FINISH: begin
				if (cmd.commit)
					res_q <= res_d;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.op == OP_UPDATE) begin
			held_q <= held_d;
		end
	end

	assign result = res_q;

endmodule

FILE: src/ssd_ctrl.sv
// sequencer for the slew distortion datapath and output word handshake
// depends on ssd_pkg and the assertion macro header
`include "stereo_sine_slew_distortion_assert.svh"

module ssd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output ssd_pkg::cmd_t cmd
);
	import ssd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_GET_X,
		ST_GET_T,
		ST_MUL_T,
		ST_GET_Q,
		ST_MUL_Q,
		ST_RD_SIN,
		ST_MUL_LIM,
		ST_GET_LIM,
		ST_UPDATE,
		ST_MUL_LVL,
		ST_GET_Y,
		ST_MUL_DRY,
		ST_MUL_WET,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	op_t op;
	logic commit;

	assign commit = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				op = OP_IDLE;
				state_d = in_valid ? ST_MUL_X : ST_IDLE;
			end
			ST_MUL_X: begin
				op = OP_MUL_X;
				state_d = ST_GET_X;
			end
			ST_GET_X: begin
				op = OP_GET_X;
				state_d = ST_GET_T;
			end
			ST_GET_T: begin
				op = OP_GET_T;
				state_d = ST_MUL_T;
			end
			ST_MUL_T: begin
				op = OP_MUL_T;
				state_d = ST_GET_Q;
			end
			ST_GET_Q: begin
				op = OP_GET_Q;
				state_d = ST_MUL_Q;
			end
			ST_MUL_Q: begin
				op = OP_MUL_Q;
				state_d = ST_RD_SIN;
			end
			ST_RD_SIN: begin
				op = OP_RD_SIN;
				state_d = ST_MUL_LIM;
			end
			ST_MUL_LIM: begin
				op = OP_MUL_LIM;
				state_d = ST_GET_LIM;
			end
			ST_GET_LIM: begin
				op = OP_GET_LIM;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				op = OP_UPDATE;
				state_d = ST_MUL_LVL;
			end
			ST_MUL_LVL: begin
				op = OP_MUL_LVL;
				state_d = ST_GET_Y;
			end
			ST_GET_Y: begin
				op = OP_GET_Y;
				state_d = ST_MUL_DRY;
			end
			ST_MUL_DRY: begin
				op = OP_MUL_DRY;
				state_d = ST_MUL_WET;
			end
			ST_MUL_WET: begin
				op = OP_MUL_WET;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				op = OP_FINISH;
				state_d = commit ? ST_IDLE : ST_FINISH;
			end
			default: begin
				op = OP_IDLE;
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.op = op;
	assign cmd.commit = commit;

	`SSD_ASSERT_NEXT(a_load_starts, cmd.load, cmd.op == OP_MUL_X, "accepted word did not start")
	`SSD_ASSERT_IMPL(a_commit_free, cmd.commit, !out_valid_q || out_ready, "result overwritten")
	`SSD_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "committed result not shown")
	`SSD_ASSERT_NEXT(a_finish_waits, (cmd.op == OP_FINISH) && !cmd.commit, cmd.op == OP_FINISH, "finished word dropped")

endmodule

FILE: src/stereo_sine_slew_distortion.sv
// top level of the stereo slew distortion block: config registers and two channel lanes
// depends on ssd_pkg, ssd_ctrl and ssd_chan
//
// Each accepted stereo word runs through a fixed 15-step sequence in which each channel lane
// uses its own single multiplier seven times, once per step that needs it; a new frame is
// taken only after the previous one has finished the sequence. The input is taken again
// while the previous result still waits in the output register; a result stalls only if
// the next one is finished before the old one is taken. Each lane holds a sine rom of
// SINE_TABLE_DEPTH+1 entries with a registered read. Reset sets the held values to zero and
// the registers to their defaults (boost, rate, level and wet all at unity). Configuration
// writes belong between frames.
module stereo_sine_slew_distortion #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ssd_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ssd_pkg::out_word_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_addr,
	input logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ssd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boost_gain <= 22'd65536;
			cfg_q.rate_scale <= 19'd65536;
			cfg_q.output_level <= 17'd65536;
			cfg_q.wet_mix <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BOOST_GAIN: cfg_q.boost_gain <= cfg_wdata[21:0];
				REG_RATE_SCALE: cfg_q.rate_scale <= cfg_wdata[18:0];
				REG_OUTPUT_LEVEL: cfg_q.output_level <= cfg_wdata[16:0];
				REG_WET_MIX: cfg_q.wet_mix <= cfg_wdata[16:0];
				default: begin
				end
			endcase
		end
	end

	ssd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd)
	);

	ssd_chan #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_chan_left (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg_q),
		.sample(in_data.left_in),
		.result(out_data.left_out)
	);

	ssd_chan #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_chan_right (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg_q),
		.sample(in_data.right_in),
		.result(out_data.right_out)
	);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// testbench for stereo_sine_slew_distortion: frames and register settings in, predicted frames out
// depends on ssd_pkg and the stereo_sine_slew_distortion rtl
module tb;
	import ssd_pkg::*;

	localparam int SINE_DEPTH = 1024;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_FRAMES = 200;
	localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S_MIN = 24'sh800000;

	class frame_scoreboard;
		localparam longint HALF_PI_Q30_C = 64'sd1686629713;
		localparam longint PHASE_GAIN = 64'sd6710746;
		localparam longint PHASE_CLIP = 64'sd16776865;
		localparam longint ONE_Q23 = 64'sd8388608;
		localparam longint HELD_MAX = 64'sd2147483647;
		localparam longint HELD_MIN = -64'sd2147483648;
		localparam longint OUT_MAX = 64'sd8388607;
		localparam longint OUT_MIN = -64'sd8388608;

		logic [21:0] boost_gain;
		logic [18:0] rate_scale;
		logic [16:0] output_level;
		logic [16:0] wet_mix;
		logic signed [31:0] held_left;
		logic signed [31:0] held_right;
		longint sine_q24 [SINE_DEPTH+1];
		out_word_t expected_frames [$];
		int errors;

		function new();
			longint unsigned ang, ang2, term;
			longint sum, v;
			for (int i = 0; i <= SINE_DEPTH; i++) begin
				ang = (longint'(i) * HALF_PI_Q30_C + SINE_DEPTH / 2) / SINE_DEPTH;
				ang2 = (ang * ang) >> 30;
				term = ang;
				sum = longint'(ang);
				for (int n = 1; n <= 7; n++) begin
					term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1)
						sum = sum - longint'(term);
					else
						sum = sum + longint'(term);
				end
				v = (sum + 32) >>> 6;
				if (v < 0)
					v = 0;
				if (v > 64'sd16777216)
					v = 64'sd16777216;
				sine_q24[i] = v;
			end
			boost_gain = 22'd65536;
			rate_scale = 19'd65536;
			output_level = 17'd65536;
			wet_mix = 17'd65536;
			held_left = '0;
			held_right = '0;
			errors = 0;
		endfunction

		static function longint round_shift(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function void set_reg(reg_idx_t idx, logic [21:0] val);
			case (idx)
				REG_BOOST_GAIN: boost_gain = val;
				REG_RATE_SCALE: rate_scale = val[18:0];
				REG_OUTPUT_LEVEL: output_level = val[16:0];
				REG_WET_MIX: wet_mix = val[16:0];
				default: begin
				end
			endcase
		endfunction

		function longint slew_limit(longint t);
			longint h, q, idx;
			h = (t * PHASE_GAIN) >>> 23;
			if (h < 0)
				h = 0;
			if (h > PHASE_CLIP)
				h = PHASE_CLIP;
			q = (h <= ONE_Q23) ? 2 * h : 2 * (2 * ONE_Q23 - h);
			idx = round_shift(q * SINE_DEPTH, 24);
			if (idx < 0)
				idx = 0;
			if (idx > SINE_DEPTH)
				idx = SINE_DEPTH;
			return round_shift(sine_q24[idx] * longint'(rate_scale), 17);
		endfunction

		function logic signed [23:0] process_sample(logic signed [23:0] sample,
				inout logic signed [31:0] held);
			longint dry, x, step, lim, acc, y;
			dry = sample;
			x = round_shift(dry * longint'(boost_gain), 16);
			step = x - longint'(held);
			if (step > 0) begin
				lim = slew_limit(ONE_Q23 - x);
				if (step > lim)
					step = lim;
			end else if (step < 0) begin
				lim = slew_limit(x + ONE_Q23);
				if (step < -lim)
					step = -lim;
			end
			acc = longint'(held) + step;
			if (acc > HELD_MAX)
				acc = HELD_MAX;
			if (acc < HELD_MIN)
				acc = HELD_MIN;
			held = acc[31:0];
			y = acc;
			if (output_level < 17'd65536)
				y = round_shift(y * longint'(output_level), 16);
			if (wet_mix < 17'd65536)
				y = round_shift(dry * (64'sd65536 - longint'(wet_mix)) + y * longint'(wet_mix), 16);
			if (y > OUT_MAX)
				y = OUT_MAX;
			if (y < OUT_MIN)
				y = OUT_MIN;
			return y[23:0];
		endfunction

		function void note_input(in_word_t w);
			out_word_t e;
			e.left_out = process_sample(w.left_in, held_left);
			e.right_out = process_sample(w.right_in, held_right);
			expected_frames.push_back(e);
		endfunction

		function void check_output(out_word_t got);
			out_word_t e;
			if (expected_frames.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected word %0d / %0d", $realtime, got.left_out,
						got.right_out);
				return;
			end
			e = expected_frames.pop_front();
			if (got.left_out !== e.left_out || got.right_out !== e.right_out) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
						$realtime, e.left_out, got.left_out, e.right_out, got.right_out);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	frame_scoreboard sb;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	int idle_cycles = 0;
	logic signed [23:0] last_left = '0;
	logic signed [23:0] last_right = '0;

	stereo_sine_slew_distortion #(
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_input(in_data);
		if (out_valid && out_ready)
			sb.check_output(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = out_idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic in_word_t frame(logic signed [23:0] l, logic signed [23:0] r);
		in_word_t w;
		w.left_in = l;
		w.right_in = r;
		return w;
	endfunction

	function automatic logic signed [23:0] next_sample(logic signed [23:0] prev);
		longint v;
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
			1: return '0;
			2, 3, 4: return 24'($urandom);
			default: begin
				v = longint'(prev) + longint'($urandom_range(0, 8192)) - 4096;
				if (v > 64'sd8388607)
					v = 64'sd8388607;
				if (v < -64'sd8388608)
					v = -64'sd8388608;
				return v[23:0];
			end
		endcase
	endfunction

	task automatic send_frame(in_word_t w);
		int gap;
		gap = in_idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [21:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_config(logic [21:0] boost, logic [18:0] rate, logic [16:0] level,
			logic [16:0] wet);
		put_reg(REG_BOOST_GAIN, boost);
		put_reg(REG_RATE_SCALE, 22'(rate));
		put_reg(REG_OUTPUT_LEVEL, 22'(level));
		put_reg(REG_WET_MIX, 22'(wet));
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic [21:0] boost;
		logic [18:0] rate;
		logic [16:0] level, wet;
		case ($urandom_range(0, 5))
			0: boost = 22'h3FFFFF;
			1: boost = 22'd65536;
			2: boost = 22'($urandom_range(0, 65535));
			3: boost = 22'($urandom);
			default: boost = 22'($urandom_range(65536, 2097152));
		endcase
		case ($urandom_range(0, 4))
			0: rate = '0;
			1: rate = 19'h7FFFF;
			2: rate = 19'($urandom);
			default: rate = 19'($urandom_range(0, 327680));
		endcase
		case ($urandom_range(0, 4))
			0: level = '0;
			1: level = 17'd65536;
			2: level = 17'($urandom);
			default: level = 17'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 4))
			0: wet = '0;
			1: wet = 17'd65536;
			2: wet = 17'($urandom);
			default: wet = 17'($urandom_range(0, 65536));
		endcase
		load_config(boost, rate, level, wet);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_frame(frame(24'sd0, 24'sd0));
		send_frame(frame(S_MAX, S_MIN));
		send_frame(frame(S_MIN, S_MAX));
		send_frame(frame(S_MAX, S_MAX));
		send_frame(frame(S_MIN, S_MIN));
		send_frame(frame(24'sd1, -24'sd1));
		drain();

		// boost and rate at full width, level and wet above unity
		load_config(22'h3FFFFF, 19'h7FFFF, 17'h1FFFF, 17'h1FFFF);
		send_frame(frame(S_MAX, S_MIN));
		send_frame(frame(S_MIN, S_MAX));
		send_frame(frame(24'sd0, 24'sd0));
		send_frame(frame(S_MAX, S_MAX));
		drain();

		// everything at zero
		load_config('0, '0, '0, '0);
		send_frame(frame(S_MAX, S_MIN));
		send_frame(frame(24'sh555555, 24'shAAAAAA));
		send_frame(frame(24'sd0, 24'sd0));
		drain();

		// zero rate holds the last value
		load_config(22'd524288, '0, 17'd32768, 17'd32768);
		send_frame(frame(S_MAX, S_MIN));
		send_frame(frame(S_MIN, S_MAX));
		drain();

		load_config(22'd1, 19'd1, 17'd65536, 17'd65535);
		send_frame(frame(S_MAX, S_MIN));
		send_frame(frame(S_MIN, S_MAX));
		send_frame(frame(24'sh400000, -24'sh400000));
		drain();

		load_config(22'd65536, 19'd327680, 17'd65535, 17'd1);
		send_frame(frame(24'sh100000, -24'sh100000));
		send_frame(frame(24'sh200000, -24'sh200000));
		send_frame(frame(24'sh300000, -24'sh300000));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_config();
			in_idle_on = $urandom_range(0, 3) != 0;
			out_idle_on = $urandom_range(0, 3) != 0;
			for (int k = 0; k < PHASE_FRAMES; k++) begin
				last_left = next_sample(last_left);
				last_right = next_sample(last_right);
				send_frame(frame(last_left, last_right));
			end
			drain();
		end

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: stereo_sine_slew_distortion.f
+incdir+src
src/ssd_pkg.sv
src/ssd_chan.sv
src/ssd_ctrl.sv
src/stereo_sine_slew_distortion.sv
tb/tb.sv
